// ===== hdl/rtsc_pkg.sv =====
`default_nettype none

package rtsc_pkg;

    // payload widths
    localparam int WORD_W   = 16;
    localparam int ADDR_W   = 4;
    localparam int SETTLE_W = 10;
    localparam int RSSI_W   = 12;
    localparam int SUM_W    = 17;
    localparam int CFG_W    = SETTLE_W;
    localparam int CFG_IDX_W = 2;

    // register indexes on the config channel
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REG_ADDR  = CFG_IDX_W'(1);

    // frame layout: address, write bit, 20-bit data field
    localparam int DATA_BITS  = 16;
    localparam int FIELD_BITS = 20;
    localparam int FRAME_BITS = ADDR_W + 1 + FIELD_BITS;
    localparam int BIT_IDX_W  = 5;

    // converter resolution actually used
    localparam int RSSI_BITS = 12;
    localparam int RSSI_KEEP = (RSSI_BITS < RSSI_W) ? RSSI_BITS : RSSI_W;
    localparam logic [RSSI_W-1:0] RSSI_MASK = RSSI_W'((64'd1 << RSSI_KEEP) - 64'd1);

    localparam int SAMPLE_COUNT_DEF = 20;

    localparam logic [SETTLE_W-1:0] SETTLE_RST = SETTLE_W'(75);
    localparam logic [ADDR_W-1:0]   ADDR_RST   = ADDR_W'(1);

endpackage

`default_nettype wire

// ===== hdl/rtsc_avg_div.sv =====
`default_nettype none

// Truncated mean: sum / SAMPLE_COUNT by reciprocal multiply (exact for SUM_W-bit sums).
module rtsc_avg_div #(
    parameter int SAMPLE_COUNT = rtsc_pkg::SAMPLE_COUNT_DEF
) (
    input  wire logic [rtsc_pkg::SUM_W-1:0]  sum,
    output logic      [rtsc_pkg::RSSI_W-1:0] mean
);

    localparam int LOG_D = $clog2(SAMPLE_COUNT);
    localparam int SHIFT = rtsc_pkg::SUM_W + LOG_D;
    localparam int MUL_W = rtsc_pkg::SUM_W + 1;
    localparam int PROD_W = rtsc_pkg::SUM_W + MUL_W;
    localparam logic [MUL_W-1:0] RECIP =
        MUL_W'(((64'd1 << SHIFT) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(sum) * PROD_W'(RECIP);
    assign mean = prod[SHIFT +: rtsc_pkg::RSSI_W];

endmodule

`default_nettype wire

// ===== hdl/receiver_tune_and_rssi_scan_top.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  start_req, channel_word, ms_tick, rssi_sample
// out       source     out_valid / out_stall spi_clock, spi_data, spi_select, busy_res,
//                                           rssi_valid, rssi_average
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per clock when out is not stalled; each item yields one result item
// through the sequencer stage, then the averaging multiply stage.
// The whole pipe advances together: in_stall follows a held, stalled result.
// Reset (rst_n low, async) leaves the sequencer idle, settle 75 ms, address 1.
// Config writes are always taken (cfg_ready tied high).
module receiver_tune_and_rssi_scan_top #(
    parameter int SAMPLE_COUNT = rtsc_pkg::SAMPLE_COUNT_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              start_req,
    input  wire logic [rtsc_pkg::WORD_W-1:0]       channel_word,
    input  wire logic                              ms_tick,
    input  wire logic [rtsc_pkg::RSSI_W-1:0]       rssi_sample,

    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   spi_clock,
    output logic                                   spi_data,
    output logic                                   spi_select,
    output logic                                   busy_res,
    output logic                                   rssi_valid,
    output logic      [rtsc_pkg::RSSI_W-1:0]       rssi_average,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rtsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rtsc_pkg::CFG_W-1:0]        cfg_data
);

    localparam int CNT_W = $clog2(SAMPLE_COUNT + 1);
    localparam logic [rtsc_pkg::SETTLE_W-1:0]  ELAPSED_MAX   = '1;

    typedef enum logic [3:0] {
        MODE_DONE   = 4'b0001,
        MODE_TUNE   = 4'b0010,
        MODE_SETTLE = 4'b0100,
        MODE_SAMPLE = 4'b1000
    } scan_mode_t;

    // frame timing: select pulse, four steps per bit, closing select, all low
    typedef enum logic [7:0] {
        PH_SEL_HI   = 8'b0000_0001,
        PH_SEL_LO   = 8'b0000_0010,
        PH_BIT_LOW  = 8'b0000_0100,
        PH_BIT_DATA = 8'b0000_1000,
        PH_BIT_CLK  = 8'b0001_0000,
        PH_BIT_END  = 8'b0010_0000,
        PH_SEL_END  = 8'b0100_0000,
        PH_ALL_LOW  = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic clock;
        logic data;
        logic select;
    } pins_t;

    // config
    logic [rtsc_pkg::SETTLE_W-1:0] settle_ms_reg;
    logic [rtsc_pkg::ADDR_W-1:0]   reg_addr_reg;

    // sequencer state
    scan_mode_t                     mode_reg, mode_next;
    phase_t                         phase_reg, phase_next;
    logic [rtsc_pkg::BIT_IDX_W-1:0] bit_idx_reg, bit_idx_next;
    logic [rtsc_pkg::WORD_W-1:0]    data_shift_reg, data_shift_next;
    logic [rtsc_pkg::SETTLE_W-1:0]  elapsed_reg, elapsed_next;
    logic [CNT_W-1:0]               samples_reg, samples_next;
    logic [rtsc_pkg::SUM_W-1:0]     sum_reg, sum_next;

    // stage 1 -> stage 2
    logic                           s1_valid_reg;
    pins_t                          s1_pins_reg, pins_next;
    logic                           s1_busy_reg;
    logic                           s1_done_reg, done_next;

    // result stage
    logic                           out_valid_reg;
    pins_t                          out_pins_reg;
    logic                           out_busy_reg;
    logic                           out_done_reg;
    logic [rtsc_pkg::RSSI_W-1:0]    last_rssi_reg;

    logic                           adv;
    logic                           in_accept;
    logic [31:0]                    frame;
    logic [rtsc_pkg::BIT_IDX_W-1:0] bit_prev;
    logic [rtsc_pkg::SETTLE_W:0]    settle_t;
    logic [rtsc_pkg::RSSI_W-1:0]    sample_eff;
    logic [rtsc_pkg::RSSI_W-1:0]    mean;

    // pipe moves when the result slot is free or being taken
    assign adv       = !out_valid_reg || !out_stall;
    assign in_stall  = !adv;
    assign in_accept = in_valid && adv;
    assign cfg_ready = 1'b1;

    assign sample_eff = rssi_sample & rtsc_pkg::RSSI_MASK;
    assign bit_prev   = bit_idx_reg - rtsc_pkg::BIT_IDX_W'(1);
    assign settle_t   = {1'b0, elapsed_reg} + (rtsc_pkg::SETTLE_W + 1)'(ms_tick);

    // frame bits in send order; data field beyond the word's bits is zero
    always_comb
    begin
        frame = '0;
        frame[rtsc_pkg::ADDR_W-1:0] = reg_addr_reg;
        frame[rtsc_pkg::ADDR_W] = 1'b1;
        for (int k = 0; k < rtsc_pkg::FIELD_BITS; k++)
        begin
            if (k < rtsc_pkg::DATA_BITS && k < rtsc_pkg::WORD_W)
                frame[rtsc_pkg::ADDR_W + 1 + k] = data_shift_reg[k];
        end
    end

    always_comb
    begin
        mode_next       = mode_reg;
        phase_next      = phase_reg;
        bit_idx_next    = bit_idx_reg;
        data_shift_next = data_shift_reg;
        elapsed_next    = elapsed_reg;
        samples_next    = samples_reg;
        sum_next        = sum_reg;
        pins_next       = '0;
        done_next       = 1'b0;

        unique case (mode_reg)
            MODE_DONE:
            begin
                if (start_req)
                begin
                    data_shift_next = channel_word;
                    phase_next      = PH_SEL_HI;
                    bit_idx_next    = '0;
                    elapsed_next    = '0;
                    samples_next    = '0;
                    sum_next        = '0;
                    mode_next       = MODE_TUNE;
                end
            end
            MODE_TUNE:
            begin
                // ticks during the frame count toward settling
                if (ms_tick && elapsed_reg != ELAPSED_MAX)
                    elapsed_next = elapsed_reg + rtsc_pkg::SETTLE_W'(1);
                unique case (phase_reg)
                    PH_SEL_HI:
                    begin
                        pins_next.select = 1'b1;
                        phase_next = PH_SEL_LO;
                    end
                    PH_SEL_LO:
                        phase_next = PH_BIT_LOW;
                    PH_BIT_LOW:
                    begin
                        // data pin still shows the previous bit; low before the first
                        pins_next.data = (bit_idx_reg != '0) ? frame[bit_prev] : 1'b0;
                        phase_next = PH_BIT_DATA;
                    end
                    PH_BIT_DATA:
                    begin
                        pins_next.data = frame[bit_idx_reg];
                        phase_next = PH_BIT_CLK;
                    end
                    PH_BIT_CLK:
                    begin
                        pins_next.data  = frame[bit_idx_reg];
                        pins_next.clock = 1'b1;
                        phase_next = PH_BIT_END;
                    end
                    PH_BIT_END:
                    begin
                        pins_next.data = frame[bit_idx_reg];
                        bit_idx_next = bit_idx_reg + rtsc_pkg::BIT_IDX_W'(1);
                        if (bit_idx_next >= rtsc_pkg::BIT_IDX_W'(rtsc_pkg::FRAME_BITS))
                            phase_next = PH_SEL_END;
                        else
                            phase_next = PH_BIT_LOW;
                    end
                    PH_SEL_END:
                    begin
                        pins_next.data   = frame[rtsc_pkg::FRAME_BITS - 1];
                        pins_next.select = 1'b1;
                        phase_next = PH_ALL_LOW;
                    end
                    PH_ALL_LOW:
                    begin
                        phase_next   = PH_SEL_HI;
                        bit_idx_next = '0;
                        mode_next    = MODE_SETTLE;
                    end
                    default:
                        phase_next = PH_SEL_HI;
                endcase
            end
            MODE_SETTLE:
            begin
                if (settle_t > {1'b0, settle_ms_reg})
                begin
                    mode_next    = MODE_SAMPLE;
                    samples_next = '0;
                    sum_next     = '0;
                end
                else
                begin
                    elapsed_next = settle_t[rtsc_pkg::SETTLE_W-1:0];
                end
            end
            MODE_SAMPLE:
            begin
                sum_next     = sum_reg + rtsc_pkg::SUM_W'(sample_eff);
                samples_next = samples_reg + CNT_W'(1);
                if (samples_next >= CNT_W'(SAMPLE_COUNT))
                begin
                    done_next = 1'b1;
                    mode_next = MODE_DONE;
                end
            end
            default:
                mode_next = MODE_DONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_ms_reg <= rtsc_pkg::SETTLE_RST;
            reg_addr_reg  <= rtsc_pkg::ADDR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == rtsc_pkg::CFG_SETTLE_MS)
                settle_ms_reg <= cfg_data;
            else if (cfg_index == rtsc_pkg::CFG_REG_ADDR)
                reg_addr_reg <= cfg_data[rtsc_pkg::ADDR_W-1:0];
        end
    end

    // stage 1: sequencer state and pin levels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_DONE;
            phase_reg      <= PH_SEL_HI;
            bit_idx_reg    <= '0;
            data_shift_reg <= '0;
            elapsed_reg    <= '0;
            samples_reg    <= '0;
            sum_reg        <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            if (in_accept)
            begin
                mode_reg       <= mode_next;
                phase_reg      <= phase_next;
                bit_idx_reg    <= bit_idx_next;
                data_shift_reg <= data_shift_next;
                elapsed_reg    <= elapsed_next;
                samples_reg    <= samples_next;
                sum_reg        <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pins_reg <= pins_next;
            s1_busy_reg <= (mode_next != MODE_DONE);
            s1_done_reg <= done_next;
        end
    end

    // stage 2: mean of the finished sum (sum_reg holds it until the next scan)
    rtsc_avg_div #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_avg_div (
        .sum  (sum_reg),
        .mean (mean)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_rssi_reg <= '0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg && s1_done_reg)
                last_rssi_reg <= mean;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            out_pins_reg <= s1_pins_reg;
            out_busy_reg <= s1_busy_reg;
            out_done_reg <= s1_done_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign spi_clock    = out_pins_reg.clock;
    assign spi_data     = out_pins_reg.data;
    assign spi_select   = out_pins_reg.select;
    assign busy_res     = out_busy_reg;
    assign rssi_valid   = out_done_reg;
    assign rssi_average = last_rssi_reg;

endmodule

`default_nettype wire

// ===== verif/tb_receiver_tune_and_rssi_scan_top.sv =====
`default_nettype none

// Self-checking bench for the tune-and-scan sequencer.
// Every input item is one timing step and yields exactly one result item, so
// a behavioural copy of the sequencer runs on each accepted input item and
// queues the pin levels it expects; the monitor pops one per accepted result.
// A short table of steps comes first (hand-written pins right after reset
// and at the start of the frame); random phases follow, each with its own
// settle time and register address, mostly complete scans with random words,
// ticks and RSSI readings, plus ignored start requests as noise.
module tb_receiver_tune_and_rssi_scan_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_LIMIT   = 1000; // cycles with no handshake at all
    localparam int unsigned PRESSURE_AT  = 600;  // result count at which rx holds off
    localparam int unsigned PRESSURE_LEN = 90;
    localparam int unsigned N_PHASES     = 5;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_TUNE,
        SCAN_SETTLE,
        SCAN_SAMPLE
    } scan_mode_t;

    typedef struct packed {
        logic                        clk_pin;
        logic                        dat_pin;
        logic                        sel_pin;
        logic                        busy;
        logic                        avg_new;
        logic [rtsc_pkg::RSSI_W-1:0] avg;
    } pin_levels_t;

    typedef struct packed {
        logic                        start;
        logic [rtsc_pkg::WORD_W-1:0] word;
        logic                        tick;
        logic [rtsc_pkg::RSSI_W-1:0] sample;
        logic                        typed;    // res below is hand-written, not predicted
        pin_levels_t                 res;
    } step_row_t;

    // Reset values: settle 75 ms, address 1.  The first rows walk into the
    // frame: select pulse, then bit 0 with the data pin still low while the
    // clock is low, address bit 0 (=1), clock high, then bit 1 which first
    // keeps the previous level.  Starts offered while busy must be ignored.
    localparam step_row_t DIRECTED_STEPS [0:23] = '{
        '{1'b0, 16'hFFFF, 1'b1, 12'hFFF, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 12'h000}},
        '{1'b1, 16'hFFFF, 1'b0, 12'h000, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 12'h000}},
        '{1'b1, 16'h0000, 1'b1, 12'hFFF, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 12'h000}},
        '{1'b0, 16'h0000, 1'b1, 12'h000, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 12'h000}},
        '{1'b0, 16'h5A5A, 1'b0, 12'hFFF, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 12'h000}},
        '{1'b0, 16'hA5A5, 1'b1, 12'h000, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 12'h000}},
        '{1'b1, 16'hFFFF, 1'b1, 12'hFFF, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 12'h000}},
        '{1'b0, 16'h0000, 1'b0, 12'h000, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 12'h000}},
        '{1'b0, 16'hFFFF, 1'b1, 12'hFFF, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 12'h000}},
        '{1'b0, 16'h0000, 1'b1, 12'h000, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 12'h000}},
        '{1'b0, 16'h1234, 1'b0, 12'h800, 1'b0, '0},
        '{1'b1, 16'hFFFF, 1'b1, 12'h001, 1'b0, '0},
        '{1'b0, 16'h0000, 1'b1, 12'hFFF, 1'b0, '0},
        '{1'b0, 16'hFFFF, 1'b0, 12'h000, 1'b0, '0},
        '{1'b1, 16'h0001, 1'b1, 12'h7FF, 1'b0, '0},
        '{1'b0, 16'h8000, 1'b1, 12'hFFF, 1'b0, '0},
        '{1'b0, 16'h0000, 1'b0, 12'h000, 1'b0, '0},
        '{1'b0, 16'hFFFF, 1'b1, 12'hFFF, 1'b0, '0},
        '{1'b1, 16'h0000, 1'b1, 12'h000, 1'b0, '0},
        '{1'b0, 16'hFFFF, 1'b1, 12'hFFF, 1'b0, '0},
        '{1'b0, 16'h0000, 1'b0, 12'h555, 1'b0, '0},
        '{1'b0, 16'hFFFF, 1'b1, 12'hAAA, 1'b0, '0},
        '{1'b0, 16'h0000, 1'b1, 12'h000, 1'b0, '0},
        '{1'b0, 16'hFFFF, 1'b0, 12'hFFF, 1'b0, '0}
    };

    // DUT-facing signals; every input has a known level from time zero
    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           in_valid     = 1'b0;
    logic                           in_stall;
    logic                           start_req    = 1'b0;
    logic [rtsc_pkg::WORD_W-1:0]    channel_word = '0;
    logic                           ms_tick      = 1'b0;
    logic [rtsc_pkg::RSSI_W-1:0]    rssi_sample  = '0;
    logic                           out_valid;
    logic                           out_stall    = 1'b1;
    logic                           spi_clock;
    logic                           spi_data;
    logic                           spi_select;
    logic                           busy_res;
    logic                           rssi_valid;
    logic [rtsc_pkg::RSSI_W-1:0]    rssi_average;
    logic                           cfg_valid    = 1'b0;
    logic                           cfg_ready;
    logic [rtsc_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
    logic [rtsc_pkg::CFG_W-1:0]     cfg_data     = '0;

    // behavioural copy of the sequencer, reset values
    scan_mode_t                     scan_mode    = SCAN_IDLE;
    logic [2:0]                     wave_phase   = '0;
    logic [rtsc_pkg::BIT_IDX_W-1:0] bit_pos      = '0;
    logic [rtsc_pkg::WORD_W-1:0]    tuned_word   = '0;
    logic [rtsc_pkg::SETTLE_W-1:0]  ms_elapsed   = '0;
    logic [4:0]                     sample_cnt   = '0;
    logic [rtsc_pkg::SUM_W-1:0]     sample_sum   = '0;
    logic [rtsc_pkg::RSSI_W-1:0]    last_average = '0;
    logic [rtsc_pkg::SETTLE_W-1:0]  settle_limit = rtsc_pkg::SETTLE_RST;
    logic [rtsc_pkg::ADDR_W-1:0]    reg_address  = rtsc_pkg::ADDR_RST;

    pin_levels_t          pending_pins [$];
    int unsigned          mismatch_count  = 0;
    int unsigned          results_checked = 0;
    int unsigned          items_offered   = 0;
    int unsigned          pins_taken      = 0;
    int unsigned          quiet_cycles    = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    receiver_tune_and_rssi_scan_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_req    (start_req),
        .channel_word (channel_word),
        .ms_tick      (ms_tick),
        .rssi_sample  (rssi_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .spi_clock    (spi_clock),
        .spi_data     (spi_data),
        .spi_select   (spi_select),
        .busy_res     (busy_res),
        .rssi_valid   (rssi_valid),
        .rssi_average (rssi_average),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Bit i of the 25-bit frame: address LSB first, write bit, data field.
    // The data field is 20 bits wide but only the low DATA_BITS carry the word.
    function automatic logic frame_bit(input int unsigned i);
        if (i < rtsc_pkg::ADDR_W)
            return reg_address[i];
        if (i == rtsc_pkg::ADDR_W)
            return 1'b1;
        if (i < rtsc_pkg::ADDR_W + 1 + rtsc_pkg::DATA_BITS)
            return tuned_word[i - rtsc_pkg::ADDR_W - 1];
        return 1'b0;
    endfunction

    // Advance the copy of the sequencer by one step and give the pin levels.
    task automatic step_scanner(input logic start, input logic [rtsc_pkg::WORD_W-1:0] word,
                                input logic tick, input logic [rtsc_pkg::RSSI_W-1:0] sample,
                                output pin_levels_t res);
        logic [rtsc_pkg::SETTLE_W:0] total;
        res = '0;
        case (scan_mode)
            SCAN_IDLE:
            begin
                // start step latches the word and clears the scan state, pins stay low
                if (start)
                begin
                    tuned_word = word;
                    wave_phase = '0;
                    bit_pos    = '0;
                    ms_elapsed = '0;
                    sample_cnt = '0;
                    sample_sum = '0;
                    scan_mode  = SCAN_TUNE;
                end
            end
            SCAN_TUNE:
            begin
                // ticks during the frame count toward the settle time
                if (tick && ms_elapsed < rtsc_pkg::SETTLE_W'(1023))
                    ms_elapsed = ms_elapsed + 1'b1;
                case (wave_phase)
                    3'd0:
                    begin
                        res.sel_pin = 1'b1;
                        wave_phase  = 3'd1;
                    end
                    3'd1: wave_phase = 3'd2;
                    3'd2:
                    begin
                        // clock-low step holds the previous bit, low before bit 0
                        res.dat_pin = (bit_pos != 0) ? frame_bit(bit_pos - 1) : 1'b0;
                        wave_phase  = 3'd3;
                    end
                    3'd3:
                    begin
                        res.dat_pin = frame_bit(bit_pos);
                        wave_phase  = 3'd4;
                    end
                    3'd4:
                    begin
                        res.dat_pin = frame_bit(bit_pos);
                        res.clk_pin = 1'b1;
                        wave_phase  = 3'd5;
                    end
                    3'd5:
                    begin
                        res.dat_pin = frame_bit(bit_pos);
                        bit_pos     = bit_pos + 1'b1;
                        wave_phase  = (bit_pos >= rtsc_pkg::FRAME_BITS) ? 3'd6 : 3'd2;
                    end
                    3'd6:
                    begin
                        res.dat_pin = frame_bit(rtsc_pkg::FRAME_BITS - 1);
                        res.sel_pin = 1'b1;
                        wave_phase  = 3'd7;
                    end
                    default:
                    begin
                        wave_phase = '0;
                        bit_pos    = '0;
                        scan_mode  = SCAN_SETTLE;
                    end
                endcase
            end
            SCAN_SETTLE:
            begin
                // settle limit read live, so a rewrite takes effect at once
                total = {1'b0, ms_elapsed} + tick;
                if (total > settle_limit)
                begin
                    scan_mode  = SCAN_SAMPLE;
                    sample_cnt = '0;
                    sample_sum = '0;
                end
                else
                    ms_elapsed = total[rtsc_pkg::SETTLE_W-1:0];
            end
            default:
            begin
                sample_sum = sample_sum + sample;
                sample_cnt = sample_cnt + 1'b1;
                if (sample_cnt >= rtsc_pkg::SAMPLE_COUNT_DEF)
                begin
                    last_average = rtsc_pkg::RSSI_W'(sample_sum /
                                   rtsc_pkg::SUM_W'(rtsc_pkg::SAMPLE_COUNT_DEF));
                    res.avg_new  = 1'b1;
                    scan_mode    = SCAN_IDLE;
                end
            end
        endcase
        res.busy = (scan_mode != SCAN_IDLE);
        res.avg  = last_average;
    endtask

    // Per-item wait for either side: bursts with no gaps one stretch in four.
    function automatic int unsigned draw_wait(input int unsigned n);
        if ((n / 50) % 4 == 1)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [rtsc_pkg::RSSI_W-1:0] got,
                               input logic [rtsc_pkg::RSSI_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                      results_checked, name, got, want));
    endtask

    // Offer one step after a random gap and hold it until taken.  Prediction
    // runs at the accepting edge, so the generator always sees the live mode.
    task automatic send_step(input logic start, input logic [rtsc_pkg::WORD_W-1:0] word,
                             input logic tick, input logic [rtsc_pkg::RSSI_W-1:0] sample,
                             input logic typed, input pin_levels_t typed_res);
        int unsigned gap;
        pin_levels_t res;
        gap = draw_wait(items_offered);
        items_offered++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        start_req    <= start;
        channel_word <= word;
        ms_tick      <= tick;
        rssi_sample  <= sample;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        step_scanner(start, word, tick, sample, res);
        pending_pins.push_back(typed ? typed_res : res);
    endtask

    task automatic write_reg(input logic [rtsc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rtsc_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == rtsc_pkg::CFG_SETTLE_MS)
            settle_limit = val[rtsc_pkg::SETTLE_W-1:0];
        else if (idx == rtsc_pkg::CFG_REG_ADDR)
            reg_address = val[rtsc_pkg::ADDR_W-1:0];
    endtask

    // Stop offering and let every queued result come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_pins.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Stimulus: reset, the directed table, then the random phases.
    initial
    begin : stimulus
        int unsigned                 ph_settle [N_PHASES];
        int unsigned                 ph_addr   [N_PHASES];
        int unsigned                 ph_len    [N_PHASES];
        int unsigned                 ph_tick   [N_PHASES];
        int unsigned                 style;
        logic                        st;
        logic [rtsc_pkg::WORD_W-1:0] w;
        logic                        tk;
        logic [rtsc_pkg::RSSI_W-1:0] smp;

        // settle extremes (0, 1023) and address extremes (15, 0); the 1023
        // phase never completes a scan and the next one cuts the settle short
        ph_settle = '{0, 1023, 0, 5, 1};
        ph_addr   = '{15, 0, 0, 10, 5};
        ph_len    = '{300, 260, 400, 420, 420};
        ph_tick   = '{6, 7, 4, 8, 2};      // tick odds out of 8
        ph_settle[2] = $urandom_range(0, 12);
        ph_addr[2]   = $urandom_range(0, 15);
        style = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 24; i++)
            send_step(DIRECTED_STEPS[i].start, DIRECTED_STEPS[i].word,
                      DIRECTED_STEPS[i].tick, DIRECTED_STEPS[i].sample,
                      DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].res);

        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_drained();
            write_reg(rtsc_pkg::CFG_SETTLE_MS, rtsc_pkg::CFG_W'(ph_settle[p]));
            write_reg(rtsc_pkg::CFG_REG_ADDR, rtsc_pkg::CFG_W'(ph_addr[p]));
            cfg_valid <= 1'b0;
            for (int n = 0; n < ph_len[p]; n++)
            begin
                // mostly starts from idle; the odd start while busy is noise
                if (scan_mode == SCAN_IDLE)
                begin
                    st = ($urandom_range(0, 2) == 0);
                    if (st)
                        style = $urandom_range(0, 3);
                end
                else
                    st = ($urandom_range(0, 7) == 0);
                w  = rtsc_pkg::WORD_W'($urandom);
                tk = ($urandom_range(0, 7) < ph_tick[p]);
                case (style)
                    0:       smp = rtsc_pkg::RSSI_W'($urandom_range(0, 4095));
                    1:       smp = '1;
                    2:       smp = '0;
                    default: smp = rtsc_pkg::RSSI_W'($urandom_range(0, 63));
                endcase
                send_step(st, w, tk, smp, 1'b0, '0);
            end
        end

        wait_drained();
        // two-stage pipe: keep clocking to catch a stray result
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Result side: random hold-offs per item, and one long hold-off so the
    // pipe fills and pushes back on the input.
    initial
    begin : result_taker
        int unsigned w;
        bit          held_off;
        held_off = 1'b0;
        forever
        begin
            if (pins_taken == PRESSURE_AT && !held_off)
            begin
                held_off = 1'b1;
                out_stall <= 1'b1;
                repeat (PRESSURE_LEN) @(posedge clk);
            end
            w = draw_wait(pins_taken);
            if (w != 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            pins_taken++;
        end
    end

    // Compare every accepted result with the oldest queued expectation.
    always @(posedge clk)
    begin : pin_monitor
        pin_levels_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pins.size() == 0)
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_checked));
            else
            begin
                want = pending_pins.pop_front();
                check_field("spi_clock", rtsc_pkg::RSSI_W'(spi_clock),
                            rtsc_pkg::RSSI_W'(want.clk_pin));
                check_field("spi_data", rtsc_pkg::RSSI_W'(spi_data),
                            rtsc_pkg::RSSI_W'(want.dat_pin));
                check_field("spi_select", rtsc_pkg::RSSI_W'(spi_select),
                            rtsc_pkg::RSSI_W'(want.sel_pin));
                check_field("busy_res", rtsc_pkg::RSSI_W'(busy_res),
                            rtsc_pkg::RSSI_W'(want.busy));
                check_field("rssi_valid", rtsc_pkg::RSSI_W'(rssi_valid),
                            rtsc_pkg::RSSI_W'(want.avg_new));
                check_field("rssi_average", rssi_average, want.avg);
            end
            results_checked++;
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

`default_nettype wire
